/* design/hbp_pkg.sv */
// shared types and constants of the huffman table bit packer
package hbp_pkg;

   // configuration of the code table
   localparam int SYMBOL_COUNT = 256;
   localparam int MAX_CODE_LEN = 32;
   localparam int CODE_BITS    = 32;
   localparam int LEN_BITS     = 6;
   localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_BITS) ? MAX_CODE_LEN : CODE_BITS;
   localparam int SYM_AW       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int TABLE_W      = CODE_BITS + LEN_BITS;

   // depth of the queue between front and back end
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCOUNT_W = $clog2(QDEPTH + 1);

   // request operation codes
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ENCODE = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   // one classified request handed to the back end
   typedef struct packed {
      logic                  flush;
      logic [CODE_BITS-1:0]  code;   // left aligned, zero below the code
      logic [LEN_BITS-1:0]   len;
   } work_type;

   // head of the work queue
   typedef struct packed {
      logic     vld;
      work_type entry;
   } head_type;

endpackage

/* design/huffman_table_bit_packer.sv */
// top level of the table-driven huffman bit packer
// A request is taken every cycle while req_full is low. Load requests write
// one code table entry in the front end and finish there. Encode and flush
// requests look up the table (registered ram read) and pass through a
// four-entry queue to the back end, which holds the bit accumulator. The
// back end takes in an encode that completes no byte and is done with it;
// any other encode is taken in and then emits its bytes in turn, holding
// while the response queue is full, before it takes the next entry. An
// encode's bytes pass the lookup stage, the queue, the work register and
// the response queue; a flush byte skips the work register. The code
// table needs no clearing after reset: the user must load every entry
// before it is used, since the block itself does not enforce this.
module huffman_table_bit_packer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_symbol,
   input  logic [31:0] req_code_word,
   input  logic [5:0]  req_code_length,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_packed_byte,
   output logic        rsp_last_of_run
);
   import hbp_pkg::*;

   logic                q_push;
   work_type            q_entry;
   logic                q_pop;
   head_type            q_head;
   logic [QCOUNT_W-1:0] q_count;

   hbp_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_operation   (req_operation),
      .req_symbol      (req_symbol),
      .req_code_word   (req_code_word),
      .req_code_length (req_code_length),
      .q_count         (q_count),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   hbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .count      (q_count)
   );

   hbp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );
endmodule

/* design/hbp_ram.sv */
// generic single write port ram with registered read
module hbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* design/hbp_front.sv */
// front end: accepts requests, loads the code table, looks up codes
module hbp_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [1:0]                  req_operation,
   input  logic [7:0]                  req_symbol,
   input  logic [31:0]                 req_code_word,
   input  logic [5:0]                  req_code_length,
   input  logic [hbp_pkg::QCOUNT_W-1:0] q_count,
   output logic                        q_push,
   output hbp_pkg::work_type           q_entry
);
   import hbp_pkg::*;

   logic                 accept;
   logic                 sym_ok;
   logic [SYM_AW-1:0]    addr;
   logic [LEN_BITS-1:0]  len_sat;
   logic [CODE_BITS-1:0] code_al;
   logic                 wr_en;
   logic [TABLE_W-1:0]   rd_data;
   logic                 s1_vld_ff, s1_vld_in;
   logic                 s1_flush_ff, s1_flush_in;
   logic [QCOUNT_W:0]    in_flight;

   // credit check: queued entries plus the one in the lookup stage
   assign in_flight = {1'b0, q_count} + (QCOUNT_W+1)'(s1_vld_ff);
   assign req_full  = (in_flight >= (QCOUNT_W+1)'(QDEPTH));
   assign accept    = req_push && !req_full;

   assign sym_ok = ({1'b0, req_symbol} < 9'(SYMBOL_COUNT));
   assign addr   = req_symbol[SYM_AW-1:0];

   // saturate the length and left align the code on load
   assign len_sat = (req_code_length > LEN_BITS'(LEN_LIMIT)) ?
                    LEN_BITS'(LEN_LIMIT) : req_code_length;
   assign code_al = req_code_word << (LEN_BITS'(CODE_BITS) - len_sat);

   // classify the request
   always_comb begin
      wr_en       = 1'b0;
      s1_vld_in   = 1'b0;
      s1_flush_in = 1'b0;
      if (accept) begin
         unique case (req_operation)
            OP_LOAD: begin
               wr_en = sym_ok;
            end
            OP_ENCODE: begin
               s1_vld_in = sym_ok;
            end
            OP_FLUSH: begin
               s1_vld_in   = 1'b1;
               s1_flush_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   hbp_ram #(
      .WIDTH (TABLE_W),
      .DEPTH (SYMBOL_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data ({code_al, len_sat}),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   // lookup stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_flush_ff <= s1_flush_in;
   end

   assign q_push        = s1_vld_ff;
   assign q_entry.flush = s1_flush_ff;
   assign q_entry.code  = rd_data[TABLE_W-1:LEN_BITS];
   assign q_entry.len   = rd_data[LEN_BITS-1:0];
endmodule

/* design/hbp_queue.sv */
// small queue of classified requests between front and back end
module hbp_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  hbp_pkg::work_type            push_entry,
   input  logic                         pop,
   output hbp_pkg::head_type            head,
   output logic [hbp_pkg::QCOUNT_W-1:0] count
);
   import hbp_pkg::*;

   work_type            slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;
   logic                do_pop;

   assign do_pop = pop && (count_ff != '0);

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head.vld   = (count_ff != '0);
   assign head.entry = slot_ff[rd_ptr_ff];
   assign count      = count_ff;
endmodule

/* design/hbp_back.sv */
// back end: packs codes into bytes and queues the finished bytes
module hbp_back (
   input  logic              clock,
   input  logic              reset,
   input  hbp_pkg::head_type head,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_packed_byte,
   output logic              rsp_last_of_run
);
   import hbp_pkg::*;

   localparam int WORK_W = CODE_BITS + 8;

   logic                busy_ff, busy_in;
   logic [WORK_W-1:0]   work_ff, work_in;
   logic [LEN_BITS-1:0] total_ff, total_in;
   logic [7:0]          pend_ff, pend_in;
   logic [2:0]          pcnt_ff, pcnt_in;
   logic [WORK_W-1:0]   joined;
   logic [LEN_BITS-1:0] joined_len;
   logic                emit;
   logic [8:0]          emit_data;
   logic [8:0]          out_ff [2];
   logic                out_wr_ff, out_wr_in;
   logic                out_rd_ff, out_rd_in;
   logic [1:0]          out_cnt_ff, out_cnt_in;
   logic                out_space;
   logic                out_pop;

   assign out_space = (out_cnt_ff != 2'd2);
   assign out_pop   = rsp_pop && (out_cnt_ff != 2'd0);

   // pending bits followed by the new code
   assign joined     = {pend_ff, CODE_BITS'(0)} |
                       ({head.entry.code, 8'd0} >> pcnt_ff);
   assign joined_len = LEN_BITS'(pcnt_ff) + head.entry.len;

   // byte packing control
   always_comb begin
      busy_in   = busy_ff;
      work_in   = work_ff;
      total_in  = total_ff;
      pend_in   = pend_ff;
      pcnt_in   = pcnt_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      emit_data = {work_ff[WORK_W-1 -: 8], 1'b0};
      if (busy_ff) begin
         if (out_space) begin
            emit      = 1'b1;
            emit_data = {work_ff[WORK_W-1 -: 8], (total_ff < LEN_BITS'(16))};
            work_in   = work_ff << 8;
            total_in  = total_ff - LEN_BITS'(8);
            if (total_ff < LEN_BITS'(16)) begin
               busy_in = 1'b0;
               pend_in = work_ff[WORK_W-9 -: 8];
               pcnt_in = total_ff[2:0];
            end
         end
      end else if (head.vld) begin
         if (head.entry.flush) begin
            if (pcnt_ff == 3'd0) begin
               q_pop = 1'b1;
            end else if (out_space) begin
               q_pop     = 1'b1;
               emit      = 1'b1;
               emit_data = {pend_ff, 1'b1};
               pend_in   = 8'd0;
               pcnt_in   = 3'd0;
            end
         end else begin
            q_pop = 1'b1;
            if (joined_len >= LEN_BITS'(8)) begin
               busy_in  = 1'b1;
               work_in  = joined;
               total_in = joined_len;
            end else begin
               pend_in = joined[WORK_W-1 -: 8];
               pcnt_in = joined_len[2:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 8'd0;
         pcnt_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         pcnt_ff <= pcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      total_ff <= total_in;
   end

   // two entry response queue
   always_comb begin
      out_wr_in  = out_wr_ff ^ emit;
      out_rd_in  = out_rd_ff ^ out_pop;
      out_cnt_in = out_cnt_ff;
      if (emit && !out_pop) begin
         out_cnt_in = out_cnt_ff + 1'b1;
      end else if (!emit && out_pop) begin
         out_cnt_in = out_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff[out_wr_ff] <= emit_data;
      end
   end

   assign rsp_empty       = (out_cnt_ff == 2'd0);
   assign rsp_packed_byte = out_ff[out_rd_ff][8:1];
   assign rsp_last_of_run = out_ff[out_rd_ff][0];
endmodule

/* design/hbp_checker.sv */
// port-level checks of the huffman table bit packer and their binding
module hbp_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [7:0] rsp_packed_byte,
   input  logic       rsp_last_of_run
);
   // nothing waits on the response side right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("response queue not empty after reset");

   // request side is open right after reset
   a_open_after_reset: assert property (@(posedge clock)
      reset |=> !req_full)
      else $error("request side full after reset");

   // request side only fills up after a request is taken
   a_full_needs_request: assert property (@(posedge clock) disable iff (reset)
      (!req_full && !req_push) |=> !req_full)
      else $error("request side became full without a request");

   // a waiting response holds until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_packed_byte) && $stable(rsp_last_of_run)))
      else $error("waiting response changed");
endmodule

bind huffman_table_bit_packer hbp_checker u_hbp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_push        (req_push),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_packed_byte (rsp_packed_byte),
   .rsp_last_of_run (rsp_last_of_run)
);

/* tb/sv/tb_huffman_table_bit_packer.sv */
// self-checking testbench for the table-driven huffman bit packer
module tb_huffman_table_bit_packer;
   timeunit 1ns;
   timeprecision 1ps;

   import hbp_pkg::*;

   // operation code the block ignores
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int RESET_CYCLES     = 6;
   localparam int RANDOM_REQUESTS  = 425;
   localparam int LONG_HOLD_CYCLES = 120;
   localparam int HOLD_SPACING     = 240;
   localparam int IDLE_LIMIT       = 2000;
   localparam int DRAIN_CYCLES     = 40;

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  sym;
      logic [31:0] word;
      logic [5:0]  len;
   } request_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } packed_type;

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_push        = 1'b0;
   logic        req_full;
   logic [1:0]  req_operation   = '0;
   logic [7:0]  req_symbol      = '0;
   logic [31:0] req_code_word   = '0;
   logic [5:0]  req_code_length = '0;
   logic        rsp_empty;
   logic        rsp_pop         = 1'b0;
   logic [7:0]  rsp_packed_byte;
   logic        rsp_last_of_run;

   // requests waiting to be offered and bytes the packer should emit
   request_type pending_requests[$];
   packed_type  expected_bytes[$];

   // model copy of the code table and the bit accumulator
   logic [31:0] code_mem [SYMBOL_COUNT];
   logic [5:0]  len_mem [SYMBOL_COUNT];
   logic [7:0]  acc_bits  = '0;
   int          pend_bits = 0;

   // entries that hold a code, so encodes never read an unwritten one
   logic [SYMBOL_COUNT-1:0] loaded_mask = '0;
   int                      loaded_syms[$];

   int   fail_count     = 0;
   int   sent_count     = 0;
   logic req_fire       = 1'b0;
   int   gap_left       = 0;
   int   burst_left     = 0;
   int   hold_left      = 0;
   int   next_hold_mark = 60;
   int   pattern_left   = 0;
   int   stall_pct      = 0;
   int   idle_cycles    = 0;

   huffman_table_bit_packer dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_operation   (req_operation),
      .req_symbol      (req_symbol),
      .req_code_word   (req_code_word),
      .req_code_length (req_code_length),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always #6 clock = ~clock;

   // queue one request and note which entries now hold a code
   function automatic void add_request(input logic [1:0] op, input logic [7:0] sym,
                                       input logic [31:0] word, input logic [5:0] len);
      request_type r;
      r.op   = op;
      r.sym  = sym;
      r.word = word;
      r.len  = len;
      pending_requests.push_back(r);
      if (op == OP_LOAD && !loaded_mask[sym]) begin
         loaded_mask[sym] = 1'b1;
         loaded_syms.push_back(int'(sym));
      end
   endfunction

   // code length mix: mostly short, some long, a few zero or overlong
   function automatic logic [5:0] rand_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 6'd0;
      if (r < 70) return 6'($urandom_range(1, 10));
      if (r < 90) return 6'($urandom_range(11, 32));
      return 6'($urandom_range(33, 63));
   endfunction

   // bit-level packing of one request, appends the bytes it emits
   function automatic void predict_packing(input request_type r);
      int unsigned left;
      logic [31:0] code;
      logic [7:0]  produced[$];
      logic [7:0]  padded;
      packed_type  item;
      case (r.op)
         OP_LOAD: begin
            if (r.sym < SYMBOL_COUNT) begin
               code_mem[r.sym] = r.word;
               len_mem[r.sym]  = (r.len > LEN_LIMIT) ? 6'(LEN_LIMIT) : r.len;
            end
         end
         OP_ENCODE: begin
            if (r.sym < SYMBOL_COUNT) begin
               code = code_mem[r.sym];
               left = len_mem[r.sym];
               // shift the code in msb first, emit each full byte
               while (left != 0) begin
                  left--;
                  acc_bits = {acc_bits[6:0], code[left]};
                  pend_bits++;
                  if (pend_bits == 8) begin
                     produced.push_back(acc_bits);
                     acc_bits  = '0;
                     pend_bits = 0;
                  end
               end
               foreach (produced[i]) begin
                  item.data = produced[i];
                  item.last = (i == produced.size() - 1);
                  expected_bytes.push_back(item);
               end
            end
         end
         OP_FLUSH: begin
            // pad a partial byte with zeros at the low end
            if (pend_bits != 0) begin
               padded    = acc_bits << (8 - pend_bits);
               item.data = padded;
               item.last = 1'b1;
               expected_bytes.push_back(item);
               acc_bits  = '0;
               pend_bits = 0;
            end
         end
         default: begin
         end
      endcase
   endfunction

   // accepted requests go through the model in order
   always @(posedge clock) begin
      req_fire = !reset && req_push && !req_full;
      if (req_fire) begin
         predict_packing(pending_requests[0]);
         void'(pending_requests.pop_front());
         sent_count++;
      end
   end

   // compare every popped byte with the oldest expected one
   always @(posedge clock) begin
      packed_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t ns: unexpected byte, expected none, got %h last %b",
                     $time, rsp_packed_byte, rsp_last_of_run);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_packed_byte !== want.data) begin
               $display("%0t ns: packed byte mismatch, expected %h, got %h",
                        $time, want.data, rsp_packed_byte);
               fail_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $display("%0t ns: last of run mismatch, expected %b, got %b",
                        $time, want.last, rsp_last_of_run);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles where neither side moves anything
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles = 0;
      end else if (idle_cycles < IDLE_LIMIT) begin
         idle_cycles++;
      end else begin
         $display("%0t ns: nothing moved for %0d cycles", $time, IDLE_LIMIT);
         $display("huffman_table_bit_packer regression: fail");
         $finish;
      end
   end

   // request driver: bursts of random length with random gaps
   always @(negedge clock) begin
      if (!reset) begin
         if (req_push && !req_fire) begin
            // request not taken yet, keep it on the ports
         end else if (gap_left > 0) begin
            gap_left--;
            req_push <= 1'b0;
         end else if (pending_requests.size() != 0) begin
            req_push        <= 1'b1;
            req_operation   <= pending_requests[0].op;
            req_symbol      <= pending_requests[0].sym;
            req_code_word   <= pending_requests[0].word;
            req_code_length <= pending_requests[0].len;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // byte receiver: stall rate changes from stretch to stretch
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (sent_count >= next_hold_mark) begin
            // long hold-off so the block backs up and raises req_full
            hold_left      = LONG_HOLD_CYCLES - 1;
            next_hold_mark += HOLD_SPACING;
            rsp_pop <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 25;
                  2: stall_pct = 60;
                  default: stall_pct = 90;
               endcase
               pattern_left = $urandom_range(8, 48);
            end
            pattern_left--;
            rsp_pop <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      int         r;
      int         made;
      logic [7:0] sym;

      // directed: aligned flush first, then table loads at the extremes
      add_request(OP_FLUSH, 8'h3c, 32'hffff_ffff, 6'd63);
      add_request(OP_LOAD, 8'h00, 32'hffff_ffff, 6'd32);
      add_request(OP_LOAD, 8'hff, 32'h0000_0000, 6'd32);
      // stray bits above the code, zero length, overlong lengths
      add_request(OP_LOAD, 8'h01, 32'hffff_fff5, 6'd3);
      add_request(OP_LOAD, 8'h02, 32'hdead_beef, 6'd0);
      add_request(OP_LOAD, 8'h03, 32'ha5a5_a5a5, 6'd63);
      add_request(OP_LOAD, 8'h04, 32'h0000_0001, 6'd1);
      add_request(OP_LOAD, 8'h05, 32'h1234_5678, 6'd33);
      add_request(OP_LOAD, 8'h80, 32'h0000_006a, 6'd7);
      // aligned long code, then a single bit padded out by a flush
      add_request(OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0);
      add_request(OP_ENCODE, 8'h04, 32'hffff_ffff, 6'd63);
      add_request(OP_FLUSH, 8'hff, 32'h0000_0000, 6'd0);
      // unaligned long codes, up to seven bits carried over
      add_request(OP_ENCODE, 8'h01, 32'h5555_aaaa, 6'd21);
      add_request(OP_ENCODE, 8'h03, 32'h0000_0000, 6'd0);
      add_request(OP_ENCODE, 8'h04, 32'h0000_0000, 6'd0);
      add_request(OP_ENCODE, 8'h01, 32'h0000_0000, 6'd0);
      add_request(OP_ENCODE, 8'h00, 32'h0000_0000, 6'd0);
      // zero length code and the unused operation emit nothing
      add_request(OP_ENCODE, 8'h02, 32'hffff_ffff, 6'd32);
      add_request(OP_UNUSED, 8'h00, 32'hffff_ffff, 6'd32);
      add_request(OP_FLUSH, 8'h55, 32'h1234_5678, 6'd5);
      add_request(OP_ENCODE, 8'hff, 32'h0000_0000, 6'd0);
      add_request(OP_ENCODE, 8'h05, 32'h0000_0000, 6'd0);
      add_request(OP_FLUSH, 8'h00, 32'h0000_0000, 6'd0);
      add_request(OP_ENCODE, 8'h80, 32'h0000_0000, 6'd0);
      add_request(OP_FLUSH, 8'h00, 32'h0000_0000, 6'd0);

      // random: mostly encodes of loaded entries, some loads, reloads and flushes
      made = 0;
      while (made < RANDOM_REQUESTS) begin
         r = $urandom_range(0, 99);
         if (r < 20) begin
            if ($urandom_range(0, 1) == 0) begin
               sym = 8'($urandom_range(0, 255));
            end else begin
               sym = 8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
            end
            add_request(OP_LOAD, sym, $urandom, rand_length());
            made++;
         end else if (r < 88) begin
            sym = 8'(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
            add_request(OP_ENCODE, sym, $urandom, 6'($urandom_range(0, 63)));
            made++;
         end else if (r < 97) begin
            add_request(OP_FLUSH, 8'($urandom_range(0, 255)), $urandom,
                        6'($urandom_range(0, 63)));
            made++;
         end else begin
            add_request(OP_UNUSED, 8'($urandom_range(0, 255)), $urandom,
                        6'($urandom_range(0, 63)));
         end
      end
      add_request(OP_FLUSH, 8'h00, 32'h0000_0000, 6'd0);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait until every request is taken and every byte has come back
      while (pending_requests.size() != 0 || expected_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("huffman_table_bit_packer regression: pass");
      end else begin
         $display("huffman_table_bit_packer regression: fail");
      end
      $finish;
   end

endmodule
